// ===== rtl/core/mwld_pkg.sv =====
// ----------------------------------------------------------------------------
// mwld_pkg: shared definitions for the multilevel walk loop detector
// Sizes, storage geometry and the request/response structs of the list store.
// ----------------------------------------------------------------------------
package mwld_pkg;

	// List geometry. LIST_LEN must be a power of two.
	localparam int LIST_LEN   = 16;
	localparam int LEVELS     = 10;
	localparam int DIST_WIDTH = 64;

	localparam int IDX_W     = $clog2(LIST_LEN);
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int DEPTH     = LEVELS * LIST_LEN;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = LEVELS * IDX_W;
	localparam int RUN_W     = $clog2(LIST_LEN + 2);
	localparam int SIZE_W    = 5;
	localparam int LMASK_W   = 9;

	typedef logic signed [DIST_WIDTH-1:0] dist_t;

	typedef struct packed {
		logic             rd;
		logic             wr;
		logic             clr;
		logic             clr_all;
		logic [LVL_W-1:0] lvl;
		logic [IDX_W-1:0] slot;
		logic             wfull;
		dist_t            wdata;
	} store_req_t;

	typedef struct packed {
		logic  full;
		dist_t data;
	} store_rsp_t;

endpackage

// ===== rtl/core/mwld_store.sv =====
// ----------------------------------------------------------------------------
// mwld_store: list entry storage
// Value memory with one access per cycle and registered read data, plus a
// flip-flop occupancy bit per entry that reset and restart clear at once.
// ----------------------------------------------------------------------------
module mwld_store (
	input  logic                clk,
	input  logic                arst_n,
	input  mwld_pkg::store_req_t req,
	output mwld_pkg::store_rsp_t rsp
);
	import mwld_pkg::*;

	dist_t             mem [DEPTH];
	logic [DEPTH-1:0]  full_q;
	logic [ADDR_W-1:0] addr;
	dist_t             rdata_q;
	logic              rfull_q;

	assign addr = ADDR_W'(int'(req.lvl) * LIST_LEN + int'(req.slot));
	assign rsp  = {rfull_q, rdata_q};

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= '0;
			rfull_q <= 1'b0;
		end else begin
			if (req.rd) begin
				rfull_q <= full_q[addr];
			end
			if (req.clr_all) begin
				full_q <= '0;
			end else if (req.wr) begin
				full_q[addr] <= req.wfull;
			end else if (req.clr) begin
				full_q[addr] <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/mwld_cmp.sv =====
// ----------------------------------------------------------------------------
// mwld_cmp: shared distance comparator
// Equality and signed less-than of two distances, used by every scan.
// ----------------------------------------------------------------------------
module mwld_cmp (
	input  mwld_pkg::dist_t a,
	input  mwld_pkg::dist_t b,
	output logic            eq,
	output logic            lt
);
	import mwld_pkg::*;

	assign eq = (a == b);
	assign lt = (a < b);

endmodule

// ===== rtl/core/multilevel_walk_loop_detector.sv =====
// ----------------------------------------------------------------------------
// multilevel_walk_loop_detector: per-walker multilevel loop detector
// Stores walk distances in circular lists per level, finds repeats, feeds
// level minima upward and empties loops once found.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                            Handshake
// -------   -----------------------------------------------  -------------------
// command   start, busy, op, distance                        start && !busy
// result    done, small_loop, small_loop_size,               done, one cycle
//           large_loop_levels
//
// Every item is handled by a sequencer that walks the list store one entry
// at a time; each store read has an address state, then a compare state.
// Each rollover level adds a minimum scan and a search, and each emptied
// slot adds a purge of all higher levels. Reset clears all occupancy bits
// and the step counter at once. The receiver cannot stall: the result
// stands for the one cycle of done.
module multilevel_walk_loop_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic signed [63:0]             distance,
	output logic                           done,
	output logic                           small_loop,
	output logic [mwld_pkg::SIZE_W-1:0]    small_loop_size,
	output logic [mwld_pkg::LMASK_W-1:0]   large_loop_levels
);
	import mwld_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_SRD    = 12'b0000_0000_0010,
		ST_SEV    = 12'b0000_0000_0100,
		ST_STORE  = 12'b0000_0000_1000,
		ST_CRD    = 12'b0000_0001_0000,
		ST_CEV    = 12'b0000_0010_0000,
		ST_CX     = 12'b0000_0100_0000,
		ST_PRD    = 12'b0000_1000_0000,
		ST_PEV    = 12'b0001_0000_0000,
		ST_NEXT   = 12'b0010_0000_0000,
		ST_MRD    = 12'b0100_0000_0000,
		ST_MEV    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	logic   done_q;

	// Step counter, kept as LEVELS base-LIST_LEN digits.
	logic [CNT_W-1:0]   cnt_q;

	// Current level, target slot and the entry being stored there.
	logic [LVL_W-1:0]   lv_q;
	logic [IDX_W-1:0]   pos_q;
	dist_t              key_q;
	logic               keyf_q;

	// Search pointer and match.
	logic [IDX_W-1:0]   s_q;
	logic [IDX_W-1:0]   t_q;
	logic [IDX_W-1:0]   hit_q;
	logic               hitf_q;

	// Emptying run and purge of higher levels.
	logic [IDX_W-1:0]   cs_q;
	logic [RUN_W-1:0]   rem_q;
	dist_t              pv_q;
	logic [LVL_W-1:0]   pl_q;
	logic [IDX_W-1:0]   pk_q;

	// Level minimum scan.
	dist_t              mval_q;
	logic               mfull_q;
	logic [IDX_W-1:0]   ms_q;

	// Result.
	logic               small_q;
	logic [SIZE_W-1:0]  size_q;
	logic [LMASK_W-1:0] levels_q;

	store_req_t sreq;
	store_rsp_t srsp;
	dist_t      cmp_b;
	logic       cmp_eq;
	logic       cmp_lt;

	logic [IDX_W-1:0] digit [LEVELS];
	logic [LEVELS-1:0] fire;
	logic [LVL_W-1:0]  nlv;
	logic [IDX_W-1:0]  diff;

	mwld_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	mwld_cmp u_cmp (
		.a  (srsp.data),
		.b  (cmp_b),
		.eq (cmp_eq),
		.lt (cmp_lt)
	);

	// Digits of the counter give each level's slot; a level rolls over into
	// the next one when all digits up to and including its own are at max.
	always_comb begin
		logic all_max;
		all_max = 1'b1;
		for (int k = 0; k < LEVELS; k++) begin
			digit[k] = cnt_q[k*IDX_W +: IDX_W];
			all_max  = all_max && (&digit[k]);
			fire[k]  = (k < LEVELS - 1) ? all_max : 1'b0;
		end
	end

	assign nlv  = lv_q + 1'b1;
	assign diff = pos_q - hit_q;

	// The comparator's second operand follows the scan in progress.
	always_comb begin
		unique case (state_q)
			ST_PEV:  cmp_b = pv_q;
			ST_MEV:  cmp_b = mval_q;
			default: cmp_b = key_q;
		endcase
	end

	// Store access for each state.
	always_comb begin
		sreq         = '0;
		sreq.lvl     = lv_q;
		sreq.slot    = s_q;
		sreq.wdata   = key_q;
		sreq.wfull   = keyf_q;
		unique case (state_q)
			ST_IDLE: begin
				sreq.clr_all = start && op;
			end
			ST_SRD: begin
				sreq.rd = 1'b1;
			end
			ST_STORE: begin
				sreq.wr   = 1'b1;
				sreq.slot = pos_q;
			end
			ST_CRD: begin
				sreq.rd   = 1'b1;
				sreq.slot = cs_q;
			end
			ST_CX: begin
				sreq.clr  = 1'b1;
				sreq.slot = cs_q;
			end
			ST_PRD: begin
				sreq.rd   = 1'b1;
				sreq.lvl  = pl_q;
				sreq.slot = pk_q;
			end
			ST_PEV: begin
				sreq.clr  = srsp.full && cmp_eq;
				sreq.lvl  = pl_q;
				sreq.slot = pk_q;
			end
			ST_MRD: begin
				sreq.rd   = 1'b1;
				sreq.slot = ms_q;
			end
			default: begin
			end
		endcase
	end

	// The result strobe follows a restart at once, or the last level of a step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_IDLE && start && op) ||
				(state_q == ST_NEXT && !fire[lv_q]);
		end
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (op) begin
							cnt_q <= '0;
						end else begin
							state_q <= ST_SRD;
						end
					end
				end
				ST_SRD: state_q <= ST_SEV;
				ST_SEV: begin
					if ((srsp.full && cmp_eq) || t_q == IDX_W'(LIST_LEN - 1)) begin
						state_q <= ST_STORE;
					end else begin
						state_q <= ST_SRD;
					end
				end
				ST_STORE: state_q <= hitf_q ? ST_CRD : ST_NEXT;
				ST_CRD:   state_q <= ST_CEV;
				ST_CEV: begin
					if (srsp.full && lv_q != LVL_W'(LEVELS - 1)) begin
						state_q <= ST_PRD;
					end else begin
						state_q <= ST_CX;
					end
				end
				ST_CX: state_q <= (rem_q == RUN_W'(1)) ? ST_NEXT : ST_CRD;
				ST_PRD: state_q <= ST_PEV;
				ST_PEV: begin
					if (pk_q == IDX_W'(LIST_LEN - 1) && pl_q == LVL_W'(LEVELS - 1)) begin
						state_q <= ST_CX;
					end else begin
						state_q <= ST_PRD;
					end
				end
				ST_NEXT: begin
					if (fire[lv_q]) begin
						state_q <= ST_MRD;
					end else begin
						state_q <= ST_IDLE;
						cnt_q   <= cnt_q + 1'b1;
					end
				end
				ST_MRD: state_q <= ST_MEV;
				ST_MEV: begin
					if (ms_q == IDX_W'(LIST_LEN - 1)) begin
						// An empty minimum is stored without a search.
						state_q <= (mfull_q || srsp.full) ? ST_SRD : ST_STORE;
					end else begin
						state_q <= ST_MRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				small_q  <= 1'b0;
				size_q   <= '0;
				levels_q <= '0;
				lv_q     <= '0;
				pos_q    <= digit[0];
				s_q      <= digit[0] - 1'b1;
				t_q      <= '0;
				hitf_q   <= 1'b0;
				key_q    <= dist_t'(distance[DIST_WIDTH-1:0]);
				keyf_q   <= 1'b1;
			end
			ST_SEV: begin
				if (srsp.full && cmp_eq) begin
					hitf_q <= 1'b1;
					hit_q  <= s_q;
				end
				s_q <= s_q - 1'b1;
				t_q <= t_q + 1'b1;
			end
			ST_STORE: begin
				cs_q  <= hit_q;
				rem_q <= (diff == '0) ? RUN_W'(LIST_LEN + 1) : RUN_W'(diff) + 1'b1;
			end
			ST_CEV: begin
				pv_q <= srsp.data;
				pl_q <= nlv;
				pk_q <= '0;
			end
			ST_CX: begin
				cs_q  <= cs_q + 1'b1;
				rem_q <= rem_q - 1'b1;
			end
			ST_PEV: begin
				pk_q <= pk_q + 1'b1;
				if (pk_q == IDX_W'(LIST_LEN - 1)) begin
					pl_q <= pl_q + 1'b1;
				end
			end
			ST_NEXT: begin
				if (lv_q == '0) begin
					small_q <= hitf_q;
					if (hitf_q) begin
						size_q <= (diff == '0) ? SIZE_W'(LIST_LEN) : SIZE_W'(diff);
					end
				end else begin
					levels_q <= levels_q | (LMASK_W'(hitf_q) << (lv_q - 1'b1));
				end
				ms_q    <= '0;
				mfull_q <= 1'b0;
			end
			ST_MEV: begin
				if (srsp.full && (!mfull_q || cmp_lt)) begin
					mval_q  <= srsp.data;
					mfull_q <= 1'b1;
				end
				ms_q <= ms_q + 1'b1;
				if (ms_q == IDX_W'(LIST_LEN - 1)) begin
					if (srsp.full && (!mfull_q || cmp_lt)) begin
						key_q  <= srsp.data;
						keyf_q <= 1'b1;
					end else begin
						key_q  <= mval_q;
						keyf_q <= mfull_q;
					end
					lv_q   <= nlv;
					pos_q  <= digit[nlv];
					s_q    <= digit[nlv] - 1'b1;
					t_q    <= '0;
					hitf_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign small_loop        = small_q && done_q;
	assign small_loop_size   = done_q ? size_q : '0;
	assign large_loop_levels = done_q ? levels_q : '0;

	// A result is only given while the sequencer is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result given while busy");

	// A processed step always makes the sequencer go busy.
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !op) |=> busy)
		else $error("process step accepted without going busy");

	// A loop size is only reported with a small loop.
	a_size_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !small_loop) |-> (small_loop_size == '0))
		else $error("loop size without small loop flag");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the multilevel walk loop detector
// Drives walk distances and restarts with random gaps and checks every result
// against a cycle-free model of the level lists that runs inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import mwld_pkg::*;

	localparam int NUM_RANDOM  = 1350;
	localparam int CYCLE_LIMIT = 100000000;
	localparam int TAIL_CYCLES = 100;

	typedef struct {
		logic        op;
		logic [63:0] walk_dist;
		int          gap;   // idle cycles the sender leaves before this item
		bit          drain; // hold this item until every result has come back
	} walk_item_t;

	typedef struct {
		logic               loop_flag;
		logic [SIZE_W-1:0]  size;
		logic [LMASK_W-1:0] levels;
	} loop_report_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               op;
	logic signed [63:0] distance;
	logic               done;
	logic               small_loop;
	logic [SIZE_W-1:0]  small_loop_size;
	logic [LMASK_W-1:0] large_loop_levels;

	walk_item_t   pending_steps[$];
	loop_report_t expected_reports[$];
	int           errors;
	int           cycles;
	int           quiet_left;

	// Shadow copy of the level lists and the step counter.
	bit          slot_full[LEVELS][LIST_LEN];
	logic [63:0] slot_val[LEVELS][LIST_LEN];
	logic [63:0] step_count;

	multilevel_walk_loop_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.distance(distance),
		.done(done),
		.small_loop(small_loop),
		.small_loop_size(small_loop_size),
		.large_loop_levels(large_loop_levels)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Stores a value at one slot after searching the level from the newest
	// slot back to the one being overwritten. Returns the hit slot or -1.
	function automatic int store_search(int lv, int pos, bit full, logic [63:0] v);
		int hit;
		int s;
		hit = -1;
		if (full) begin
			for (int t = 1; t <= LIST_LEN; t++) begin
				s = (pos + LIST_LEN - t) % LIST_LEN;
				if (slot_full[lv][s] && slot_val[lv][s] == v) begin
					hit = s;
					break;
				end
			end
		end
		slot_full[lv][pos] = full;
		slot_val[lv][pos] = v;
		return hit;
	endfunction

	// Empties the circular run from the hit up to the current slot. Each
	// emptied value is first purged from every higher level.
	function automatic void empty_run(int lv, int first, int last);
		int s;
		logic [63:0] v;
		if (first >= last)
			last += LIST_LEN;
		for (int i = first; i <= last; i++) begin
			s = i % LIST_LEN;
			if (slot_full[lv][s]) begin
				v = slot_val[lv][s];
				for (int j = lv + 1; j < LEVELS; j++)
					for (int k = 0; k < LIST_LEN; k++)
						if (slot_full[j][k] && slot_val[j][k] == v)
							slot_full[j][k] = 0;
			end
			slot_full[lv][s] = 0;
		end
	endfunction

	function automatic loop_report_t walk_step(logic is_restart, logic [63:0] d);
		loop_report_t rep;
		logic [63:0] nxt;
		logic [63:0] period;
		int pos;
		int hit;
		bit min_full;
		logic [63:0] min_val;
		rep = '{default: '0};
		if (is_restart) begin
			foreach (slot_full[i, j])
				slot_full[i][j] = 0;
			step_count = '0;
			return rep;
		end
		nxt = step_count + 64'd1;
		pos = int'(step_count % LIST_LEN);
		hit = store_search(0, pos, 1'b1, d);
		if (hit >= 0) begin
			empty_run(0, hit, pos);
			rep.loop_flag = 1'b1;
			rep.size = (pos > hit) ? SIZE_W'(pos - hit) : SIZE_W'(LIST_LEN - (hit - pos));
		end
		// Level k rolls its minimum upward when the step count crosses a
		// multiple of its period. Empty slots lose every comparison.
		for (int k = 0; k + 1 < LEVELS; k++) begin
			period = 64'd1 << (IDX_W * (k + 1));
			if (nxt % period == 0) begin
				min_full = slot_full[k][0];
				min_val = slot_val[k][0];
				for (int i = 1; i < LIST_LEN; i++)
					if (slot_full[k][i] &&
						(!min_full || $signed(slot_val[k][i]) < $signed(min_val))) begin
						min_full = 1;
						min_val = slot_val[k][i];
					end
				pos = int'((step_count / period) % LIST_LEN);
				hit = store_search(k + 1, pos, min_full, min_val);
				if (hit >= 0) begin
					empty_run(k + 1, hit, pos);
					rep.levels[k] = 1'b1;
				end
			end
		end
		step_count = nxt;
		return rep;
	endfunction

	function automatic void queue_step(logic is_restart, logic [63:0] d, bit drain = 0);
		walk_item_t it;
		it.op = is_restart;
		it.walk_dist = d;
		it.drain = drain;
		// Stretches of back-to-back items alternate with random gaps.
		if (quiet_left > 0) begin
			quiet_left--;
			it.gap = 0;
		end else begin
			it.gap = $urandom_range(0, 15);
			if ($urandom_range(0, 30) == 0)
				quiet_left = $urandom_range(10, 60);
		end
		pending_steps.push_back(it);
	endfunction

	// Sender. An item is taken at an edge with start high and busy low; the
	// next one is raised at that same edge when its gap is zero, so start is
	// assigned once per edge.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		walk_item_t it;
		bit fired;
		if (!arst_n) begin
			start <= 1'b0;
			op <= 1'b0;
			distance <= '0;
			gap_left <= 0;
		end else begin
			fired = start && !busy;
			if (fired)
				expected_reports.push_back(walk_step(op, distance));
			if (fired || !start) begin
				if (pending_steps.size() != 0 && gap_left < pending_steps[0].gap) begin
					gap_left <= gap_left + 1;
					start <= 1'b0;
				end else if (pending_steps.size() != 0 &&
					!(pending_steps[0].drain && expected_reports.size() != 0)) begin
					it = pending_steps.pop_front();
					gap_left <= 0;
					start <= 1'b1;
					op <= it.op;
					distance <= it.walk_dist;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver. Results cannot be held off, so every done is checked.
	always @(posedge clk) begin
		loop_report_t exp_rep;
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				exp_rep = expected_reports.pop_front();
				if (small_loop !== exp_rep.loop_flag) begin
					$display("%0t: small_loop expected %0b actual %0b",
						$time, exp_rep.loop_flag, small_loop);
					errors++;
				end
				if (small_loop_size !== exp_rep.size) begin
					$display("%0t: small_loop_size expected %0d actual %0d",
						$time, exp_rep.size, small_loop_size);
					errors++;
				end
				if (large_loop_levels !== exp_rep.levels) begin
					$display("%0t: large_loop_levels expected %b actual %b",
						$time, exp_rep.levels, large_loop_levels);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [63:0] pool[];
		int run_len;
		int sent;
		errors = 0;
		cycles = 0;
		quiet_left = 0;
		step_count = '0;
		foreach (slot_full[i, j])
			slot_full[i][j] = 0;
		arst_n = 1'b0;

		// Directed: extremes, an immediate repeat, a repeat whose run wraps around
		// the list, a wait for every result before a restart, then a repeat and a restart.
		queue_step(1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
		queue_step(1'b0, 64'h8000_0000_0000_0000);
		queue_step(1'b0, 64'h0);
		queue_step(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_step(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 11; i++)
			queue_step(1'b0, 64'd100 + i);
		queue_step(1'b0, 64'd100);
		queue_step(1'b0, 64'hAAAA_5555_AAAA_5555);
		queue_step(1'b1, 64'h0, 1);
		queue_step(1'b0, 64'h5555_AAAA_5555_AAAA);
		queue_step(1'b0, 64'h5555_AAAA_5555_AAAA);
		queue_step(1'b1, 64'($urandom()));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Random: episodes of walks drawn from a small pool of distances, so
		// that loops close at level 0 and minima repeat at higher levels.
		// Three steps in ten use fresh values. Most episodes are long enough to
		// roll level one, and the longest also roll level two.
		sent = 0;
		while (sent < NUM_RANDOM) begin
			run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
				: $urandom_range(100, 600);
			pool = new[$urandom_range(2, 40)];
			foreach (pool[i])
				pool[i] = {$urandom(), $urandom()} >>> $urandom_range(0, 63);
			for (int i = 0; i < run_len && sent < NUM_RANDOM; i++) begin
				if ($urandom_range(0, 9) < 7)
					queue_step(1'b0, pool[$urandom_range(0, pool.size() - 1)],
						$urandom_range(0, 199) == 0);
				else
					queue_step(1'b0, {$urandom(), $urandom()});
				sent++;
			end
			if ($urandom_range(0, 2) == 0) begin
				queue_step(1'b1, {$urandom(), $urandom()});
				sent++;
			end
		end

		while (pending_steps.size() != 0 || start || expected_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
